// File: src/multichannel_level_tracker_unit_defines.svh
// ----------------------------------------------------------------------------
// Multichannel level tracker assertion macros
// Shared concurrent assertion forms for the tracker RTL.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_LEVEL_TRACKER_UNIT_DEFINES_SVH
`define MULTICHANNEL_LEVEL_TRACKER_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define MLTU_CHECK_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define MLTU_CHECK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/mltu_pkg.sv
// ----------------------------------------------------------------------------
// Multichannel level tracker package
// Widths, opcodes and status codes of the level tracker.
// ----------------------------------------------------------------------------
package mltu_pkg;

    localparam int CHANNELS = 8;
    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam int OP_W   = 3;
    localparam int CHAN_W = 8;
    localparam int AMT_W  = 32;
    localparam int TS_W   = 32;
    localparam int ST_W   = 2;
    localparam int LVL_W  = 31;
    localparam int PCT_W  = 7;
    localparam int DVD_W  = LVL_W + PCT_W;
    localparam int CNT_W  = $clog2(DVD_W);

    typedef logic [LVL_W-1:0] t_level;
    typedef logic [PCT_W-1:0] t_pct;

    localparam logic [OP_W-1:0] OP_SET_CAP   = 3'd0;
    localparam logic [OP_W-1:0] OP_SET_REM   = 3'd1;
    localparam logic [OP_W-1:0] OP_ADD_FEED  = 3'd2;
    localparam logic [OP_W-1:0] OP_MARK_FULL = 3'd3;
    localparam logic [OP_W-1:0] OP_CONSUME   = 3'd4;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_INVALID   = 2'd1;
    localparam logic [ST_W-1:0] ST_UNDERFLOW = 2'd2;

    localparam t_pct PCT_FULL = 7'd100;

endpackage

// File: src/multichannel_level_tracker_unit.sv
// ----------------------------------------------------------------------------
// Multichannel level tracker unit
// Per-channel capacity, level, refill time, underflow mark and fill percent.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall carry one operation word (opcode,
// channel, amount, timestamp). Output channel: o_out_valid / i_out_stall
// carry one result word (status, level, fill percent, underflow flag,
// refill time) per operation, in order.
// Flow: an operation that changes a channel with nonzero level and
// capacity passes from its accept edge through an update state, the
// bit-serial divider (one dividend bit per cycle) that forms
// level*100/capacity, and a result state that raises o_out_valid.
// Operations that fail, or that leave a zero level or capacity, skip the
// divider. One operation is in work at a time, so no new word is taken
// until the last one's result has been written to the output register.
// The next word is taken while a result still waits in the output register.
// Reset clears all channel state at once (capacity zero means unconfigured)
// and empties the output register; no clearing pass is needed.
// A stalled result holds; the unit then waits at its result cycle and
// keeps o_in_stall high until the output register frees.
// ----------------------------------------------------------------------------
`include "multichannel_level_tracker_unit_defines.svh"

module multichannel_level_tracker_unit
    import mltu_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [OP_W-1:0]         i_opcode,
    input  logic [CHAN_W-1:0]       i_channel,
    input  logic signed [AMT_W-1:0] i_amount,
    input  logic [TS_W-1:0]         i_timestamp,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [ST_W-1:0]         o_status,
    output logic [LVL_W-1:0]        o_level,
    output logic [PCT_W-1:0]        o_fill_percent,
    output logic                    o_underflow_flag,
    output logic [TS_W-1:0]         o_refill_time
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    t_level          r_cap    [CHANNELS];
    t_level          r_lvl    [CHANNELS];
    logic [TS_W-1:0] r_refill [CHANNELS];
    logic            r_uf     [CHANNELS];
    t_pct            r_pct_st [CHANNELS];

    logic [1:0]       r_state;
    logic [OP_W-1:0]  r_opcode;
    logic [CH_W-1:0]  r_ch;
    logic             r_chan_ok;
    logic [AMT_W-1:0] r_amount;
    logic [TS_W-1:0]  r_stamp;
    logic [ST_W-1:0]  r_status;
    logic             r_upd;
    logic             r_use_div;
    t_pct             r_pct;

    logic [DVD_W-1:0] r_dvd;
    t_level           r_rem;
    t_pct             r_quo;
    logic             r_over;
    logic [CNT_W-1:0] r_cnt;

    logic             r_out_valid;
    logic [ST_W-1:0]  r_out_status;
    t_level           r_out_level;
    t_pct             r_out_pct;
    logic             r_out_uf;
    logic [TS_W-1:0]  r_out_refill;

    t_level          cur_cap;
    t_level          cur_lvl;
    logic            neg;
    t_level          mag;
    logic [LVL_W:0]  sum;
    t_level          n_cap;
    t_level          n_lvl;
    logic            n_upd;
    logic            n_refill;
    logic            n_uf_set;
    logic            n_div;
    logic [ST_W-1:0] n_status;

    logic [LVL_W:0]  div_trial;
    logic [LVL_W:0]  div_diff;
    logic            div_ge;
    t_pct            div_pct;
    t_pct            fin_pct;
    logic            out_free;

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_level          = r_out_level;
    assign o_fill_percent   = r_out_pct;
    assign o_underflow_flag = r_out_uf;
    assign o_refill_time    = r_out_refill;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        cur_cap  = r_cap[r_ch];
        cur_lvl  = r_lvl[r_ch];
        neg      = r_amount[AMT_W-1];
        mag      = r_amount[LVL_W-1:0];
        sum      = {1'b0, cur_lvl} + {1'b0, mag};
        n_cap    = cur_cap;
        n_lvl    = cur_lvl;
        n_upd    = 1'b0;
        n_refill = 1'b0;
        n_uf_set = 1'b0;
        n_status = ST_INVALID;
        case (r_opcode)
            OP_SET_CAP: begin
                if (!neg && mag != '0) begin
                    n_cap    = mag;
                    n_lvl    = (cur_lvl > mag) ? mag : cur_lvl;
                    n_upd    = 1'b1;
                    n_status = ST_OK;
                end
            end
            OP_SET_REM: begin
                if (!neg && cur_cap != '0) begin
                    n_lvl    = (mag > cur_cap) ? cur_cap : mag;
                    n_upd    = 1'b1;
                    n_refill = 1'b1;
                    n_status = ST_OK;
                end
            end
            OP_ADD_FEED: begin
                if (!neg && mag != '0 && cur_cap != '0) begin
                    n_lvl    = (sum > {1'b0, cur_cap}) ? cur_cap : sum[LVL_W-1:0];
                    n_upd    = 1'b1;
                    n_refill = 1'b1;
                    n_status = ST_OK;
                end
            end
            OP_MARK_FULL: begin
                if (cur_cap != '0) begin
                    n_lvl    = cur_cap;
                    n_upd    = 1'b1;
                    n_refill = 1'b1;
                    n_status = ST_OK;
                end
            end
            OP_CONSUME: begin
                if (!neg) begin
                    n_upd = 1'b1;
                    if (mag > cur_lvl) begin
                        n_lvl    = '0;
                        n_uf_set = 1'b1;
                        n_status = ST_UNDERFLOW;
                    end else begin
                        n_lvl    = cur_lvl - mag;
                        n_status = ST_OK;
                    end
                end
            end
            default: begin
            end
        endcase
        n_div = r_chan_ok && n_upd && (n_cap != '0) && (n_lvl != '0);
    end

    always_comb begin
        div_trial = {r_rem, r_dvd[DVD_W-1]};
        div_diff  = div_trial - {1'b0, cur_cap};
        div_ge    = (div_trial >= {1'b0, cur_cap});
        div_pct   = (r_over || r_quo > PCT_FULL) ? PCT_FULL : r_quo;
        fin_pct   = r_use_div ? div_pct : r_pct;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_cap[i]    <= '0;
                r_lvl[i]    <= '0;
                r_refill[i] <= '0;
                r_uf[i]     <= 1'b0;
                r_pct_st[i] <= '0;
            end
        end else begin
            if (r_out_valid && !i_out_stall && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_opcode  <= i_opcode;
                        r_ch      <= i_channel[CH_W-1:0];
                        r_chan_ok <= (i_channel < CHAN_W'(CHANNELS));
                        r_amount  <= i_amount;
                        r_stamp   <= i_timestamp;
                        r_state   <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_status  <= n_status;
                    r_upd     <= n_upd;
                    r_use_div <= n_div;
                    r_pct     <= n_upd ? '0 : r_pct_st[r_ch];
                    r_state   <= n_div ? S_DIV : S_FIN;
                    if (r_chan_ok && n_upd) begin
                        r_cap[r_ch] <= n_cap;
                        r_lvl[r_ch] <= n_lvl;
                        if (n_refill) begin
                            r_refill[r_ch] <= r_stamp;
                        end
                        if (n_refill || n_uf_set) begin
                            r_uf[r_ch] <= n_uf_set;
                        end
                    end
                    if (n_div) begin
                        r_dvd  <= DVD_W'(n_lvl) * DVD_W'(PCT_FULL);
                        r_rem  <= '0;
                        r_quo  <= '0;
                        r_over <= 1'b0;
                        r_cnt  <= '0;
                    end
                end
                S_DIV: begin
                    r_dvd  <= {r_dvd[DVD_W-2:0], 1'b0};
                    r_rem  <= div_ge ? div_diff[LVL_W-1:0] : div_trial[LVL_W-1:0];
                    r_quo  <= {r_quo[PCT_W-2:0], div_ge};
                    r_over <= r_over | r_quo[PCT_W-1];
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(DVD_W - 1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                        if (r_chan_ok) begin
                            if (r_upd) begin
                                r_pct_st[r_ch] <= fin_pct;
                            end
                            r_out_status <= r_status;
                            r_out_level  <= r_lvl[r_ch];
                            r_out_pct    <= fin_pct;
                            r_out_uf     <= r_uf[r_ch];
                            r_out_refill <= r_refill[r_ch];
                        end else begin
                            r_out_status <= ST_INVALID;
                            r_out_level  <= '0;
                            r_out_pct    <= '0;
                            r_out_uf     <= 1'b0;
                            r_out_refill <= '0;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `MLTU_CHECK_NOW(a_level_within_cap, i_clk, i_rst_n, (r_state == S_FIN) && r_chan_ok, r_lvl[r_ch] <= r_cap[r_ch], "level above capacity")
    `MLTU_CHECK_NOW(a_pct_range, i_clk, i_rst_n, r_out_valid, r_out_pct <= PCT_FULL, "fill percent above 100")
    `MLTU_CHECK_NOW(a_underflow_result, i_clk, i_rst_n, r_out_valid && (r_out_status == ST_UNDERFLOW), r_out_uf && (r_out_level == '0), "underflow result without empty level and mark")
    `MLTU_CHECK_NEXT(a_accept_to_exec, i_clk, i_rst_n, i_in_valid && !o_in_stall, r_state == S_EXEC, "accepted word did not start update")
    `MLTU_CHECK_NOW(a_div_count, i_clk, i_rst_n, r_state == S_DIV, r_cnt < CNT_W'(DVD_W), "divider ran past dividend width")

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// Multichannel level tracker testbench
// Drives operation words through the valid/stall input channel and checks
// every result word, field by field and in order, against the typed rows'
// fixed values or a predictor's copy of the per-channel capacity, level,
// refill time, underflow mark and fill percent. A directed table comes
// first, then random words under varying sender and receiver idling.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mltu_pkg::*;

    typedef struct packed {
        logic [ST_W-1:0] status;
        t_level          level;
        t_pct            pct;
        logic            uflow;
        logic [TS_W-1:0] refill;
    } t_level_result;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [CHAN_W-1:0] ch;
        logic [AMT_W-1:0]  amt;
        logic [TS_W-1:0]   ts;
        logic              typed;
        t_level_result     res;
    } t_op_row;

    logic                    i_clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [OP_W-1:0]         opcode = '0;
    logic [CHAN_W-1:0]       channel = '0;
    logic signed [AMT_W-1:0] amount = '0;
    logic [TS_W-1:0]         timestamp = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [ST_W-1:0]         status;
    logic [LVL_W-1:0]        level;
    logic [PCT_W-1:0]        fill_percent;
    logic                    underflow_flag;
    logic [TS_W-1:0]         refill_time;

    t_level          cap_s [CHANNELS];
    t_level          lvl_s [CHANNELS];
    logic [TS_W-1:0] rt_s  [CHANNELS];
    logic            uf_s  [CHANNELS];
    t_pct            pct_s [CHANNELS];

    t_level_result result_q [$];
    t_op_row       directed_q [$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    bit          hold_request  = 1'b0;
    int          errors        = 0;
    int          words_sent    = 0;
    int          results_seen  = 0;
    int          underflows    = 0;
    int          rejects       = 0;

    multichannel_level_tracker_unit DUT (
        .i_clk            (i_clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_opcode         (opcode),
        .i_channel        (channel),
        .i_amount         (amount),
        .i_timestamp      (timestamp),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_status         (status),
        .o_level          (level),
        .o_fill_percent   (fill_percent),
        .o_underflow_flag (underflow_flag),
        .o_refill_time    (refill_time)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic t_pct fill_of(t_level cap, t_level lvl);
        logic [63:0] q;
        if (cap == '0 || lvl == '0) return '0;
        q = ({33'd0, lvl} * 64'd100) / {33'd0, cap};
        return (q > 64'd100) ? PCT_FULL : q[PCT_W-1:0];
    endfunction

    function automatic t_level_result apply_level_op(logic [OP_W-1:0] op,
                                                     logic [CHAN_W-1:0] ch,
                                                     logic [AMT_W-1:0] amt,
                                                     logic [TS_W-1:0] ts);
        t_level_result   r;
        logic            neg;
        t_level          mag;
        logic [63:0]     sum;
        logic [ST_W-1:0] st;
        logic [CH_W-1:0] c;
        r   = '0;
        neg = amt[AMT_W-1];
        mag = amt[LVL_W-1:0];
        st  = ST_INVALID;
        if (ch >= CHANNELS) begin
            r.status = ST_INVALID;
            return r;
        end
        c = ch[CH_W-1:0];
        case (op)
            OP_SET_CAP: begin
                if (!neg && mag != '0) begin
                    cap_s[c] = mag;
                    if (lvl_s[c] > mag) lvl_s[c] = mag;
                    st = ST_OK;
                end
            end
            OP_SET_REM: begin
                if (!neg && cap_s[c] != '0) begin
                    lvl_s[c] = (mag > cap_s[c]) ? cap_s[c] : mag;
                    rt_s[c]  = ts;
                    uf_s[c]  = 1'b0;
                    st = ST_OK;
                end
            end
            OP_ADD_FEED: begin
                if (!neg && mag != '0 && cap_s[c] != '0) begin
                    sum = {33'd0, lvl_s[c]} + {33'd0, mag};
                    if (sum > {33'd0, cap_s[c]}) sum = {33'd0, cap_s[c]};
                    lvl_s[c] = sum[LVL_W-1:0];
                    rt_s[c]  = ts;
                    uf_s[c]  = 1'b0;
                    st = ST_OK;
                end
            end
            OP_MARK_FULL: begin
                if (cap_s[c] != '0) begin
                    lvl_s[c] = cap_s[c];
                    rt_s[c]  = ts;
                    uf_s[c]  = 1'b0;
                    st = ST_OK;
                end
            end
            OP_CONSUME: begin
                if (!neg) begin
                    if (mag > lvl_s[c]) begin
                        lvl_s[c] = '0;
                        uf_s[c]  = 1'b1;
                        st = ST_UNDERFLOW;
                    end else begin
                        lvl_s[c] = lvl_s[c] - mag;
                        st = ST_OK;
                    end
                end
            end
            default: begin
            end
        endcase
        if (st != ST_INVALID) pct_s[c] = fill_of(cap_s[c], lvl_s[c]);
        r.status = st;
        r.level  = lvl_s[c];
        r.pct    = pct_s[c];
        r.uflow  = uf_s[c];
        r.refill = rt_s[c];
        return r;
    endfunction

    function automatic t_op_row row(logic [OP_W-1:0] op, logic [CHAN_W-1:0] ch,
                                    logic [AMT_W-1:0] amt, logic [TS_W-1:0] ts,
                                    logic typed, logic [ST_W-1:0] st,
                                    t_level lvl, t_pct pct, logic uf,
                                    logic [TS_W-1:0] rt);
        t_op_row w;
        w.op = op;
        w.ch = ch;
        w.amt = amt;
        w.ts = ts;
        w.typed = typed;
        w.res.status = st;
        w.res.level = lvl;
        w.res.pct = pct;
        w.res.uflow = uf;
        w.res.refill = rt;
        return w;
    endfunction

    task automatic send_word(t_op_row w);
        t_level_result r;
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
        end
        @(negedge i_clk);
        in_valid  <= 1'b1;
        opcode    <= w.op;
        channel   <= w.ch;
        amount    <= w.amt;
        timestamp <= w.ts;
        do @(posedge i_clk); while (in_stall);
        r = apply_level_op(w.op, w.ch, w.amt, w.ts);
        result_q.push_back(w.typed ? w.res : r);
        words_sent++;
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic run_random(int count);
        t_op_row     w;
        int unsigned pick;
        t_level      cap;
        t_level      lvl;
        for (int n = 0; n < count; n++) begin
            w = '0;
            w.ts = $urandom;
            if ($urandom_range(99) < 12) begin
                w.op  = OP_W'($urandom_range(7));
                w.ch  = ($urandom_range(1)) ? CHAN_W'($urandom_range(255))
                                            : CHAN_W'($urandom_range(CHANNELS - 1));
                w.amt = $urandom;
            end else begin
                w.ch = CHAN_W'($urandom_range(CHANNELS - 1));
                cap  = cap_s[w.ch[CH_W-1:0]];
                lvl  = lvl_s[w.ch[CH_W-1:0]];
                pick = $urandom_range(99);
                if (pick < 15) w.op = OP_SET_CAP;
                else if (pick < 35) w.op = OP_SET_REM;
                else if (pick < 60) w.op = OP_ADD_FEED;
                else if (pick < 70) w.op = OP_MARK_FULL;
                else w.op = OP_CONSUME;
                case (w.op)
                    OP_SET_CAP: begin
                        pick = $urandom_range(99);
                        if (pick < 70) w.amt = $urandom_range(20000, 1);
                        else if (pick < 90) w.amt = $urandom_range(32'h7FFF_FFFF, 1);
                        else w.amt = ($urandom_range(1)) ? 32'h7FFF_FFFF : 32'd1;
                    end
                    OP_SET_REM:  w.amt = $urandom_range({1'b0, cap} + cap / 4 + 1, 0);
                    OP_ADD_FEED: w.amt = $urandom_range(cap / 2 + 1, 1);
                    OP_MARK_FULL: w.amt = $urandom;
                    default:     w.amt = $urandom_range({1'b0, lvl} + lvl / 8 + 2, 0);
                endcase
            end
            send_word(w);
        end
    endtask

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_level_result exp_r;
        if (rst_n && out_valid && !out_stall) begin
            results_seen++;
            if (status == ST_UNDERFLOW) underflows++;
            if (status == ST_INVALID) rejects++;
            if (result_q.size() == 0) begin
                $display("%0t: unexpected result word, status %0d level 0x%0h", $time,
                         status, level);
                errors++;
            end else begin
                exp_r = result_q.pop_front();
                check_field("status", 32'(exp_r.status), 32'(status));
                check_field("level", 32'(exp_r.level), 32'(level));
                check_field("fill_percent", 32'(exp_r.pct), 32'(fill_percent));
                check_field("underflow_flag", 32'(exp_r.uflow), 32'(underflow_flag));
                check_field("refill_time", exp_r.refill, refill_time);
            end
        end
    end

    initial begin : receiver
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    initial begin : stimulus
        for (int c = 0; c < CHANNELS; c++) begin
            cap_s[c] = '0;
            lvl_s[c] = '0;
            rt_s[c]  = '0;
            uf_s[c]  = 1'b0;
            pct_s[c] = '0;
        end
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;

        //                   op            ch      amount        timestamp     typed status
        directed_q.push_back(row(OP_CONSUME,   8'd0,   32'd0,        32'd0,        1, ST_OK,
                                 '0, '0, 1'b0, '0));
        directed_q.push_back(row(OP_SET_REM,   8'd1,   32'd5,        32'd7,        1, ST_INVALID,
                                 '0, '0, 1'b0, '0));
        directed_q.push_back(row(OP_ADD_FEED,  8'd2,   32'd5,        32'd7,        1, ST_INVALID,
                                 '0, '0, 1'b0, '0));
        directed_q.push_back(row(OP_MARK_FULL, 8'd3,   32'd0,        32'd7,        1, ST_INVALID,
                                 '0, '0, 1'b0, '0));
        directed_q.push_back(row(OP_SET_CAP,   8'd0,   32'd0,        32'd0,        1, ST_INVALID,
                                 '0, '0, 1'b0, '0));
        directed_q.push_back(row(OP_SET_CAP,   8'd0,   32'hFFFF_FFFF, 32'd0,       1, ST_INVALID,
                                 '0, '0, 1'b0, '0));
        directed_q.push_back(row(OP_SET_CAP,   8'd8,   32'd100,      32'd0,        1, ST_INVALID,
                                 '0, '0, 1'b0, '0));
        directed_q.push_back(row(OP_CONSUME,   8'd255, 32'd0,        32'hFFFF_FFFF, 1, ST_INVALID,
                                 '0, '0, 1'b0, '0));
        directed_q.push_back(row(3'd5,         8'd0,   32'd10,       32'd0,        1, ST_INVALID,
                                 '0, '0, 1'b0, '0));
        directed_q.push_back(row(3'd6,         8'd1,   32'd10,       32'd0,        1, ST_INVALID,
                                 '0, '0, 1'b0, '0));
        directed_q.push_back(row(3'd7,         8'd1,   32'd10,       32'd0,        1, ST_INVALID,
                                 '0, '0, 1'b0, '0));
        directed_q.push_back(row(OP_SET_CAP,   8'd7,   32'h7FFF_FFFF, 32'd0,       1, ST_OK,
                                 '0, '0, 1'b0, '0));
        directed_q.push_back(row(OP_MARK_FULL, 8'd7,   32'd0,        32'hFFFF_FFFF, 1, ST_OK,
                                 31'h7FFF_FFFF, PCT_FULL, 1'b0, 32'hFFFF_FFFF));
        directed_q.push_back(row(OP_CONSUME,   8'd7,   32'h7FFF_FFFF, 32'd0,       1, ST_OK,
                                 '0, '0, 1'b0, 32'hFFFF_FFFF));
        directed_q.push_back(row(OP_CONSUME,   8'd7,   32'd1,        32'd0,        1, ST_UNDERFLOW,
                                 '0, '0, 1'b1, 32'hFFFF_FFFF));
        directed_q.push_back(row(OP_CONSUME,   8'd7,   32'h8000_0000, 32'd0,       1, ST_INVALID,
                                 '0, '0, 1'b1, 32'hFFFF_FFFF));
        directed_q.push_back(row(OP_SET_REM,   8'd7,   -32'sd5,      32'd0,        1, ST_INVALID,
                                 '0, '0, 1'b1, 32'hFFFF_FFFF));
        directed_q.push_back(row(OP_ADD_FEED,  8'd7,   32'd0,        32'd0,        1, ST_INVALID,
                                 '0, '0, 1'b1, 32'hFFFF_FFFF));
        directed_q.push_back(row(OP_SET_CAP,   8'd0,   32'd1000,     32'd0,        0, ST_OK,
                                 '0, '0, 1'b0, '0));
        directed_q.push_back(row(OP_SET_REM,   8'd0,   32'd333,      32'h1234_5678, 0, ST_OK,
                                 '0, '0, 1'b0, '0));
        directed_q.push_back(row(OP_ADD_FEED,  8'd0,   32'd5000,     32'h5555_AAAA, 0, ST_OK,
                                 '0, '0, 1'b0, '0));
        directed_q.push_back(row(OP_SET_CAP,   8'd0,   32'd500,      32'd0,        0, ST_OK,
                                 '0, '0, 1'b0, '0));
        directed_q.push_back(row(OP_CONSUME,   8'd0,   32'd1,        32'd0,        0, ST_OK,
                                 '0, '0, 1'b0, '0));
        directed_q.push_back(row(OP_SET_REM,   8'd7,   32'h7FFF_FFFF, 32'd1,       0, ST_OK,
                                 '0, '0, 1'b0, '0));
        directed_q.push_back(row(OP_ADD_FEED,  8'd7,   32'h7FFF_FFFF, 32'hAAAA_5555, 0, ST_OK,
                                 '0, '0, 1'b0, '0));
        directed_q.push_back(row(OP_CONSUME,   8'd0,   32'h5555_5555, 32'd0,       0, ST_OK,
                                 '0, '0, 1'b0, '0));

        send_idle_pct = 9;
        recv_idle_pct = 48;
        foreach (directed_q[i]) send_word(directed_q[i]);
        drain_results();

        run_random(280);
        hold_request = 1'b1;
        run_random(270);
        drain_results();

        send_idle_pct = 48;
        recv_idle_pct = 9;
        run_random(560);
        drain_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(560);
        drain_results();
        repeat (60) @(posedge i_clk);

        $display("Sent %0d operation words over all five opcodes and bad inputs,", words_sent);
        $display("compared %0d results (%0d underflow, %0d rejected).", results_seen,
                 underflows, rejects);
        if (errors == 0 && result_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+src
src/mltu_pkg.sv
src/multichannel_level_tracker_unit.sv
test/tb.sv
